// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i while out of reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check an implication whose consequence must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  `ASSERT_CHK(label, (trig) |=> (cons), msg)

`endif

// ===== src/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants of the trend run segmenter.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int SampleWidthDef = 16;
  localparam int CountWidthDef  = 15;

  // Result queue depth: room for the two results of one item plus slack.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_RISE = 2'd1,
    DIR_FALL = 2'd2
  } dir_e;

  localparam logic KIND_RUN      = 1'b0;
  localparam logic KIND_EXTREMUM = 1'b1;

  typedef struct packed {
    logic first;
    logic second;
  } trs_push_t;

endpackage

// ===== src/trs_if.sv =====
// ----------------------------------------------------------------------------
// trs_if
// Valid/ready channels for samples in and segment results out.
// ----------------------------------------------------------------------------
interface trs_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_WIDTH-1:0]  sample;
  logic                            last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface trs_out_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 15
);
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic signed [COUNT_WIDTH:0]     signed_length;
  logic signed [SAMPLE_WIDTH-1:0]  value;
  logic                            end_of_sequence;

  modport source (output valid, output kind, output signed_length, output value,
                  output end_of_sequence, input ready);
  modport sink   (input valid, input kind, input signed_length, input value,
                  input end_of_sequence, output ready);
endinterface

// ===== src/trs_core.sv =====
// ----------------------------------------------------------------------------
// trs_core
// Run tracking state and result formation for one accepted sample.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trs_core #(
  parameter int SAMPLE_WIDTH = trs_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = trs_pkg::CountWidthDef,
  parameter int RES_WIDTH    = COUNT_WIDTH + SAMPLE_WIDTH + 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_i,
  output trs_pkg::trs_push_t             push_o,
  output logic [RES_WIDTH-1:0]           res_a_o,
  output logic [RES_WIDTH-1:0]           res_b_o
);
  import trs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CountTwo = COUNT_WIDTH'(2);

  logic signed [SAMPLE_WIDTH-1:0] prev_q, prev_d;
  logic signed [SAMPLE_WIDTH-1:0] start_q, start_d;
  logic                           have_q, have_d;
  dir_e                           dir_q, dir_d;
  logic [COUNT_WIDTH-1:0]         count_q, count_d;
  dir_e                           step_dir;
  logic                           reversed;
  logic signed [COUNT_WIDTH:0]    old_len, new_len;

  function automatic logic signed [COUNT_WIDTH:0] run_len(dir_e dir,
                                                          logic [COUNT_WIDTH-1:0] cnt);
    logic signed [COUNT_WIDTH:0] mag;
    mag = $signed({1'b0, cnt});
    return (dir == DIR_FALL) ? -mag : mag;
  endfunction

  always_comb begin
    if (sample_i > prev_q) begin
      step_dir = DIR_RISE;
    end else if (sample_i < prev_q) begin
      step_dir = DIR_FALL;
    end else begin
      step_dir = DIR_NONE;
    end
  end

  always_comb begin
    prev_d   = prev_q;
    start_d  = start_q;
    have_d   = have_q;
    dir_d    = dir_q;
    count_d  = count_q;
    reversed = 1'b0;
    if (!have_q) begin
      have_d = 1'b1;
      prev_d = sample_i;
    end else begin
      if (dir_q == DIR_NONE) begin
        if (step_dir != DIR_NONE) begin
          dir_d   = step_dir;
          start_d = prev_q;
          count_d = CountTwo;
        end
      end else if (step_dir == DIR_NONE || step_dir == dir_q) begin
        // saturate rather than wrap
        if (count_q != CountMax) begin
          count_d = count_q + COUNT_WIDTH'(1);
        end
      end else begin
        reversed = 1'b1;
        dir_d    = step_dir;
        start_d  = prev_q;
        count_d  = CountTwo;
      end
      prev_d = sample_i;
    end
  end

  assign old_len = run_len(dir_q, count_q);
  assign new_len = run_len(dir_d, count_d);

  // Slot A goes out first, slot B second.
  always_comb begin
    push_o  = '0;
    res_a_o = {KIND_RUN, old_len, start_q, 1'b0};
    res_b_o = {KIND_EXTREMUM, (COUNT_WIDTH + 1)'(0), sample_i, 1'b1};
    if (reversed) begin
      push_o.first = 1'b1;
      if (last_i) begin
        push_o.second = 1'b1;
        res_b_o       = {KIND_EXTREMUM, new_len, sample_i, 1'b1};
      end
    end else if (last_i) begin
      if (dir_d != DIR_NONE) begin
        push_o.first  = 1'b1;
        push_o.second = 1'b1;
        res_a_o       = {KIND_RUN, new_len, start_d, 1'b0};
      end else begin
        push_o.first = 1'b1;
        res_a_o      = res_b_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      dir_q   <= DIR_NONE;
      count_q <= '0;
      prev_q  <= '0;
      start_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        // sequence closed: start over
        have_q  <= 1'b0;
        dir_q   <= DIR_NONE;
        count_q <= '0;
        prev_q  <= '0;
        start_q <= '0;
      end else begin
        have_q  <= have_d;
        dir_q   <= dir_d;
        count_q <= count_d;
        prev_q  <= prev_d;
        start_q <= start_d;
      end
    end
  end

  `ASSERT_NEXT(a_last_clears, accept_i && last_i, !have_q && dir_q == DIR_NONE,
               "state not cleared after last item")
  `ASSERT_CHK(a_dir_needs_prev, dir_q != DIR_NONE |-> have_q,
              "direction set without a previous sample")
  `ASSERT_CHK(a_run_min_two, dir_q != DIR_NONE |-> count_q >= CountTwo,
              "open run shorter than two samples")

endmodule

// ===== src/trs_fifo.sv =====
// ----------------------------------------------------------------------------
// trs_fifo
// Small result queue taking up to two entries per cycle, giving out one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trs_fifo #(
  parameter int RES_WIDTH = 35
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trs_pkg::trs_push_t   push_i,
  input  logic [RES_WIDTH-1:0] res_a_i,
  input  logic [RES_WIDTH-1:0] res_b_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output logic [RES_WIDTH-1:0] data_o
);
  import trs_pkg::*;

  localparam logic [FifoAw:0] Depth     = (FifoAw + 1)'(FifoDepth);
  localparam logic [FifoAw:0] RoomLimit = (FifoAw + 1)'(FifoDepth - 2);

  logic [RES_WIDTH-1:0] mem_q [FifoDepth];
  logic [FifoAw-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [FifoAw:0]      cnt_q, cnt_d;
  logic [FifoAw:0]      n_push;
  logic                 pop;

  assign n_push  = (FifoAw + 1)'(push_i.first) + (FifoAw + 1)'(push_i.second);
  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= RoomLimit);

  assign wr_d  = wr_q + n_push[FifoAw-1:0];
  assign rd_d  = rd_q + FifoAw'(pop);
  assign cnt_d = cnt_q + n_push - (FifoAw + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= res_a_i;
    end
    if (push_i.second) begin
      mem_q[wr_q + FifoAw'(1)] <= res_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_CHK(a_no_overflow, cnt_q <= Depth, "result queue overflow")
  `ASSERT_CHK(a_push_in_order, push_i.second |-> push_i.first,
              "second slot pushed without the first")
  `ASSERT_CHK(a_push_needs_room, push_i.first |-> room_o,
              "push while the queue lacks room")

endmodule

// ===== src/trend_run_segmenter.sv =====
// ----------------------------------------------------------------------------
// trend_run_segmenter
// Splits a stream of signed samples into monotonic runs.
// ----------------------------------------------------------------------------
// Usage: samples enter on sample_in_i (sample, last), one per cycle while ready.
// Results leave on result_out_o: a finished run (kind 0) carries its signed
// length and start value; the closing extremum (kind 1) carries the final
// sample and end_of_sequence. An item causes zero, one or two results; only
// the item marked last, or a reversal on it, gives two.
// A result is written to the result queue when its item is accepted and
// leaves from its head behind earlier results; one item is taken per cycle
// while ready, and a last item's second result is absorbed by the four-entry queue.
// sample_in_i.ready holds while the queue has room for two more results, so
// a stalled receiver back-pressures the input once the queue fills up, and
// nothing is dropped.
// Reset clears the run state and empties the queue; the next item starts a
// new sequence, as it does after every last item.
// ----------------------------------------------------------------------------
module trend_run_segmenter #(
  parameter int SAMPLE_WIDTH = trs_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = trs_pkg::CountWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  trs_in_if.sink    sample_in_i,
  trs_out_if.source result_out_o
);
  import trs_pkg::*;

  localparam int ResWidth = COUNT_WIDTH + SAMPLE_WIDTH + 3;

  trs_push_t            push;
  logic [ResWidth-1:0]  res_a, res_b, head;
  logic                 room;
  logic                 accept;

  assign sample_in_i.ready = room;
  assign accept            = sample_in_i.valid && room;

  trs_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .RES_WIDTH    (ResWidth)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_in_i.sample),
    .last_i   (sample_in_i.last),
    .push_o   (push),
    .res_a_o  (res_a),
    .res_b_o  (res_b)
  );

  trs_fifo #(
    .RES_WIDTH (ResWidth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept ? push : trs_push_t'('0)),
    .res_a_i (res_a),
    .res_b_i (res_b),
    .room_o  (room),
    .valid_o (result_out_o.valid),
    .pop_i   (result_out_o.ready),
    .data_o  (head)
  );

  assign result_out_o.kind            = head[ResWidth-1];
  assign result_out_o.signed_length   = $signed(head[ResWidth-2 -: COUNT_WIDTH + 1]);
  assign result_out_o.value           = $signed(head[SAMPLE_WIDTH:1]);
  assign result_out_o.end_of_sequence = head[0];

endmodule
